>>> rtl/msort_pkg.sv
// shared types and constants for the merge sort engine
package msort_pkg;

    localparam int DATA_W = 32;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;        // input request taken, store or drop it
        logic start;       // set up the first merge pass
        logic prep;        // prime the read registers for a new pass
        logic merge;       // one merge step, one element written
        logic drain_rd;    // fetch the next sorted element
        logic drain_next;  // result request taken
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic single;      // set holds one element
        logic pass_last;   // this merge step writes the last element of a pass
        logic sort_done;   // the pass in flight is the final one
        logic drain_last;  // element on the output is the final one
    } t_stat;

    typedef enum logic [5:0] {
        S_LOAD  = 6'b000001,
        S_START = 6'b000010,
        S_PREP  = 6'b000100,
        S_MERGE = 6'b001000,
        S_DRD   = 6'b010000,
        S_DOUT  = 6'b100000
    } t_state;

endpackage

>>> rtl/msort_ctrl.sv
// sequencing state machine: load, merge passes, drain
module msort_ctrl import msort_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    input  logic  i_s_tlast,
    input  logic  i_m_tready,
    input  t_stat i_stat,
    output logic  o_s_tready,
    output logic  o_m_tvalid,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
                if (i_s_tvalid && i_s_tlast) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                o_cmd.start = 1'b1;
                n_state     = i_stat.single ? S_DRD : S_PREP;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_MERGE;
            end
            S_MERGE: begin
                o_cmd.merge = 1'b1;
                if (i_stat.pass_last) begin
                    n_state = i_stat.sort_done ? S_DRD : S_PREP;
                end
            end
            S_DRD: begin
                o_cmd.drain_rd = 1'b1;
                n_state        = S_DOUT;
            end
            S_DOUT: begin
                o_m_tvalid       = 1'b1;
                o_cmd.drain_next = i_m_tready;
                if (i_m_tready) begin
                    n_state = i_stat.drain_last ? S_LOAD : S_DRD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

endmodule

>>> rtl/msort_dpath.sv
// ping-pong element memories, merge indices and compare for bottom-up merge sort
module msort_dpath import msort_pkg::*; #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  logic signed [DATA_W-1:0] i_value,
    output t_stat                    o_stat,
    output logic signed [DATA_W-1:0] o_value,
    output logic                     o_last,
    output logic                     o_ovf
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int IW = CW + 2;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);
    localparam logic [CW-1:0] ONE     = CW'(1);
    localparam logic [IW-1:0] ONE_X   = IW'(1);
    localparam logic [IW-1:0] TWO_X   = IW'(2);

    logic [DATA_W-1:0] r_mem0 [MAX_ITEMS];
    logic [DATA_W-1:0] r_mem1 [MAX_ITEMS];

    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic [CW-1:0] r_w;
    logic [CW-1:0] r_il;
    logic [CW-1:0] r_ir;
    logic [CW-1:0] r_mid;
    logic [CW-1:0] r_hi;
    logic [CW-1:0] r_k;
    logic [CW-1:0] r_d;
    logic          r_src;
    logic [DATA_W-1:0] r_dl;
    logic [DATA_W-1:0] r_dr;

    logic [IW-1:0] cnt_x;
    logic [IW-1:0] w2_x;
    logic [IW-1:0] w4_x;
    logic [IW-1:0] run_mid_x;
    logic [IW-1:0] run_hi_x;
    logic          in_l;
    logic          in_r;
    logic          take_l;
    logic          run_end;
    logic [DATA_W-1:0] wdata;
    logic [CW-1:0] n_il;
    logic [CW-1:0] n_ir;
    logic [CW-1:0] rd_l;
    logic [CW-1:0] rd_r;
    logic          rd_en;
    logic          room;

    function automatic logic [CW-1:0] clip_to(input logic [IW-1:0] a,
                                               input logic [IW-1:0] lim);
        clip_to = (a > lim) ? lim[CW-1:0] : a[CW-1:0];
    endfunction

    assign cnt_x     = IW'(r_count);
    assign w2_x      = IW'(r_w) << 1;
    assign w4_x      = IW'(r_w) << 2;
    assign run_mid_x = IW'(r_hi) + IW'(r_w);
    assign run_hi_x  = IW'(r_hi) + w2_x;
    assign room      = (r_count < MAX_CNT);

    // left head wins ties; an exhausted side never wins
    assign in_l    = (r_il < r_mid);
    assign in_r    = (r_ir < r_hi);
    assign take_l  = in_l && (!in_r || ($signed(r_dl) <= $signed(r_dr)));
    assign wdata   = take_l ? r_dl : r_dr;
    assign run_end = (r_k == r_hi - ONE);

    always_comb begin
        if (run_end) begin
            n_il = r_hi;
            n_ir = clip_to(run_mid_x, cnt_x);
        end else begin
            n_il = r_il + CW'(take_l);
            n_ir = r_ir + CW'(!take_l);
        end
        if (i_cmd.merge) begin
            rd_l = n_il;
            rd_r = n_ir;
        end else if (i_cmd.prep) begin
            rd_l = r_il;
            rd_r = r_ir;
        end else begin
            rd_l = r_d;
            rd_r = r_ir;
        end
    end

    assign rd_en = i_cmd.prep | i_cmd.merge | i_cmd.drain_rd;

    // memory 0: filled on load, destination of passes reading memory 1
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && room) begin
            r_mem0[r_count[AW-1:0]] <= i_value;
        end else if (i_cmd.merge && r_src) begin
            r_mem0[r_k[AW-1:0]] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.merge && !r_src) begin
            r_mem1[r_k[AW-1:0]] <= wdata;
        end
    end

    // registered reads from the pass source
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            if (r_src) begin
                r_dl <= r_mem1[rd_l[AW-1:0]];
                r_dr <= r_mem1[rd_r[AW-1:0]];
            end else begin
                r_dl <= r_mem0[rd_l[AW-1:0]];
                r_dr <= r_mem0[rd_r[AW-1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_w     <= '0;
            r_il    <= '0;
            r_ir    <= '0;
            r_mid   <= '0;
            r_hi    <= '0;
            r_k     <= '0;
            r_d     <= '0;
            r_src   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (room) begin
                    r_count <= r_count + ONE;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.start) begin
                r_w   <= ONE;
                r_il  <= '0;
                r_mid <= clip_to(ONE_X, cnt_x);
                r_ir  <= clip_to(ONE_X, cnt_x);
                r_hi  <= clip_to(TWO_X, cnt_x);
                r_k   <= '0;
                r_d   <= '0;
                r_src <= 1'b0;
            end
            if (i_cmd.merge) begin
                if (o_stat.pass_last) begin
                    // next pass: width doubles, source and destination swap
                    r_src <= ~r_src;
                    r_d   <= '0;
                    r_k   <= '0;
                    r_il  <= '0;
                    r_w   <= w2_x[CW-1:0];
                    r_mid <= clip_to(w2_x, cnt_x);
                    r_ir  <= clip_to(w2_x, cnt_x);
                    r_hi  <= clip_to(w4_x, cnt_x);
                end else begin
                    r_k  <= r_k + ONE;
                    r_il <= n_il;
                    r_ir <= n_ir;
                    if (run_end) begin
                        r_mid <= clip_to(run_mid_x, cnt_x);
                        r_hi  <= clip_to(run_hi_x, cnt_x);
                    end
                end
            end
            if (i_cmd.drain_next) begin
                if (o_stat.drain_last) begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                end else begin
                    r_d <= r_d + ONE;
                end
            end
        end
    end

    assign o_stat.single     = (r_count == ONE);
    assign o_stat.pass_last  = (r_k == r_count - ONE);
    assign o_stat.sort_done  = (w2_x >= cnt_x);
    assign o_stat.drain_last = (r_d == r_count - ONE);

    assign o_value = r_dl;
    assign o_last  = o_stat.drain_last;
    assign o_ovf   = r_ovf;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("element count beyond capacity");

    a_heads_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.merge |-> (r_il <= r_mid) && (r_ir <= r_hi))
        else $error("merge head ran past its run");

    a_heads_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.merge |-> (IW'(r_il) + IW'(r_ir) == IW'(r_k) + IW'(r_mid)))
        else $error("merge heads out of step with write index");

endmodule

>>> rtl/merge_sort_engine.sv
// merge sort engine top level: stream ports, controller and datapath
// sequence: after the last request of a set of n elements, a setup state, then
//   ceil(log2 n) merge passes of a prepare state and one step per element, then
//   a read state and an output state per result; load takes one element a cycle,
//   merges write one at a time through the single compare and one-write memory port
// reset: synchronous active low, clears the state machine, counts and overflow flag;
//   element memories are not cleared, only entries written for the current set are read
module merge_sort_engine import msort_pkg::*; #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input stream
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic signed [DATA_W-1:0] s_axis_tdata,   // [31:0] value
    input  logic                     s_axis_tlast,   // last element of the set
    // output stream
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic signed [DATA_W-1:0] m_axis_tdata,   // [31:0] sorted_value
    output logic                     m_axis_tlast,   // last_out
    output logic [0:0]               m_axis_tuser    // [0] overflow
);

    t_cmd  cmd;
    t_stat stat;
    logic  ovf;

    // state machine: accepts requests only while loading, presents one result at a time
    msort_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tlast  (s_axis_tlast),
        .i_m_tready (m_axis_tready),
        .i_stat     (stat),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_cmd      (cmd)
    );

    // two element memories in ping-pong, bottom-up passes of doubling run width
    msort_dpath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_value (s_axis_tdata),
        .o_stat  (stat),
        .o_value (m_axis_tdata),
        .o_last  (m_axis_tlast),
        .o_ovf   (ovf)
    );

    // overflow flag rides on every result of the set
    assign m_axis_tuser = ovf;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while results are being delivered");

endmodule

>>> sim/tb_merge_sort_engine.sv
// testbench for the merge sort engine: directed and random sets checked against a behavioral sort
module tb_merge_sort_engine;
    import msort_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int SET_CAPACITY   = 64;
    localparam int RAND_REQUESTS  = 80;
    localparam int DRAIN_CYCLES   = 200;     // covers the setup state plus a stray merge pass
    localparam int TIMEOUT_CYCLES = 400000;

    typedef logic signed [DATA_W-1:0] t_value;

    localparam t_value VALUE_MAX = t_value'(32'h7FFF_FFFF);
    localparam t_value VALUE_MIN = t_value'(32'h8000_0000);

    typedef enum int {
        VAL_FULL,
        VAL_NARROW,
        VAL_EXTREME
    } t_value_mode;

    typedef struct {
        t_value value;
        logic   last;
    } t_request;

    typedef struct {
        t_value value;
        logic   last;
        logic   overflow;
    } t_result;

    logic   i_clk         = 1'b0;
    logic   i_rst_n       = 1'b0;
    logic   s_axis_tvalid = 1'b0;
    logic   s_axis_tready;
    t_value s_axis_tdata  = '0;      // [31:0] value
    logic   s_axis_tlast  = 1'b0;
    logic   m_axis_tvalid;
    logic   m_axis_tready = 1'b0;
    t_value m_axis_tdata;            // [31:0] sorted_value
    logic   m_axis_tlast;
    logic [0:0] m_axis_tuser;        // [0] overflow

    t_request pending_requests[$];   // stimulus not yet offered
    t_result  sorted_results[$];     // sorted values still owed by the block
    t_value   set_elements[$];       // elements kept for the set in progress
    logic     set_dropped = 1'b0;    // an element of this set did not fit

    bit in_taken  = 1'b0;
    bit calm_in   = 1'b0;
    bit calm_out  = 1'b0;
    int in_gap    = 0;
    int out_stall = 0;
    int fail_count = 0;

    merge_sort_engine #(
        .MAX_ITEMS(SET_CAPACITY)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_value make_value(input t_value_mode mode);
        case (mode)
            VAL_NARROW: begin
                // small range so that ties are common
                return t_value'(int'($urandom_range(0, 8)) - 4);
            end
            VAL_EXTREME: begin
                case ($urandom_range(0, 4))
                    0:       return VALUE_MAX;
                    1:       return VALUE_MIN;
                    2:       return t_value'(0);
                    3:       return t_value'(-1);
                    default: return t_value'(1);
                endcase
            end
            default: begin
                return t_value'($urandom());
            end
        endcase
    endfunction

    task automatic add_request(input t_value value, input logic last);
        t_request req;
        req.value = value;
        req.last  = last;
        pending_requests.insert(pending_requests.size(), req);
    endtask

    task automatic add_set(input int count, input t_value_mode mode);
        for (int k = 0; k < count; k++)
            add_request(make_value(mode), logic'(k == count - 1));
    endtask

    // keeps up to the capacity, and on the last request emits the set in ascending order
    task automatic record_element(input t_value value, input logic last);
        t_value  ordered[$];
        t_value  key;
        t_result res;
        int      j;
        if (set_elements.size() < SET_CAPACITY)
            set_elements.insert(set_elements.size(), value);
        else
            set_dropped = 1'b1;
        if (last) begin
            ordered = set_elements;
            for (int i = 1; i < ordered.size(); i++) begin
                key = ordered[i];
                j   = i;
                while (j > 0 && ordered[j-1] > key) begin
                    ordered[j] = ordered[j-1];
                    j--;
                end
                ordered[j] = key;
            end
            foreach (ordered[k]) begin
                res.value    = ordered[k];
                res.last     = logic'(k == ordered.size() - 1);
                res.overflow = set_dropped;
                sorted_results.insert(sorted_results.size(), res);
            end
            set_elements.delete();
            set_dropped = 1'b0;
        end
    endtask

    // accepted requests feed the prediction, accepted results are checked in order
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                in_taken = 1'b1;
                record_element(s_axis_tdata, s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (sorted_results.size() == 0) begin
                    $error("unexpected result: sorted_value %0d last %0b overflow %0b",
                           m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
                    fail_count++;
                end else begin
                    want = sorted_results[0];
                    sorted_results.delete(0);
                    if (m_axis_tdata !== want.value) begin
                        $error("sorted_value: expected %0d, got %0d", want.value, m_axis_tdata);
                        fail_count++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last_out: expected %0b, got %0b", want.last, m_axis_tlast);
                        fail_count++;
                    end
                    if (m_axis_tuser[0] !== want.overflow) begin
                        $error("overflow: expected %0b, got %0b", want.overflow, m_axis_tuser[0]);
                        fail_count++;
                    end
                end
            end
        end
    end

    // request driver: holds a request until taken, then an optional gap before the next
    always @(negedge i_clk) begin
        t_request req;
        if ($urandom_range(0, 199) == 0)
            calm_in = !calm_in;
        if (i_rst_n && (!s_axis_tvalid || in_taken)) begin
            in_taken = 1'b0;
            if (in_gap > 0) begin
                in_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
                req = pending_requests[0];
                pending_requests.delete(0);
                s_axis_tdata  <= req.value;
                s_axis_tlast  <= req.last;
                s_axis_tvalid <= 1'b1;
                in_gap = calm_in ? 0 : pick_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result side back pressure
    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0)
            calm_out = !calm_out;
        if (out_stall > 0) begin
            out_stall--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            out_stall = calm_out ? 0 : pick_gap();
        end
    end

    initial begin
        int set_idx;
        int rand_count;
        int n;
        int pick;

        // single elements pass through unchanged
        add_request(VALUE_MAX, 1'b1);
        add_request(VALUE_MIN, 1'b1);
        // two elements out of order
        add_request(t_value'(5), 1'b0);
        add_request(t_value'(-5), 1'b1);
        // extremes with repeats
        add_request(VALUE_MAX, 1'b0);
        add_request(VALUE_MIN, 1'b0);
        add_request(t_value'(0), 1'b0);
        add_request(t_value'(-1), 1'b0);
        add_request(t_value'(1), 1'b0);
        add_request(VALUE_MAX, 1'b0);
        add_request(VALUE_MIN, 1'b1);
        // all equal
        add_request(t_value'(7), 1'b0);
        add_request(t_value'(7), 1'b0);
        add_request(t_value'(7), 1'b1);
        // strictly descending, odd count
        for (int v = 9; v >= 5; v--)
            add_request(t_value'(v), logic'(v == 5));
        // already ascending
        for (int v = -3; v <= 2; v++)
            add_request(t_value'(v), logic'(v == 2));

        // random sets, one filling the store and then overrunning it
        set_idx    = 0;
        rand_count = 0;
        while (rand_count < RAND_REQUESTS || set_idx < 2) begin
            if (set_idx == 1) begin
                n = SET_CAPACITY + $urandom_range(1, 4);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 75)
                    n = $urandom_range(1, 8);
                else
                    n = $urandom_range(9, 20);
            end
            add_set(n, t_value_mode'($urandom_range(0, 2)));
            rand_count += n;
            set_idx++;
        end

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_requests.size() != 0 || s_axis_tvalid || sorted_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("simulation failed");
        $finish;
    end

endmodule
